/* rtl/tcw_pkg.sv */
// tcw_pkg: shared types and constants of the text console writer
// no dependencies; imported by tcw_ctrl, tcw_datapath and text_console_writer
package tcw_pkg;

  localparam int CELL_IDX_W = 11;
  localparam int CHAR_W     = 8;
  localparam int ATTR_W     = 8;
  localparam int CMD_W      = 2;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 32;

  localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  localparam logic [CHAR_W-1:0] CHAR_NUL       = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CHAR_NEWLINE   = 8'h0a;
  localparam logic [CHAR_W-1:0] CHAR_SPACE     = 8'h20;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_CLEAR,
    ST_SCROLL,
    ST_READ,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic accept;
    logic exec;
    logic fill;
    logic fill_zero;
    logic scroll;
    logic capture;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_scroll;
    logic is_clear;
    logic is_read;
    logic fill_last;
    logic scroll_last;
    logic out_free;
  } dp_stat_t;

endpackage

/* rtl/text_console_writer.sv */
// text_console_writer: top level of the text console writer
// depends on tcw_pkg, tcw_ctrl and tcw_datapath
//
// A put, a read or an empty command passes from the execute state (and for a
// read, the capture state) to the done state, where its result is loaded into
// the output register once that is free; a put that runs past the last cell
// moves every row up through the single write port of the screen memory, one
// cell a cycle; a clear writes one cell a cycle. After reset the screen memory
// is zeroed one cell a cycle, and no command is taken until it is done;
// the clear attribute register takes writes at any time. The next command
// is taken while the previous result still waits in the output register.
module text_console_writer #(
  parameter int ROWS = 25,
  parameter int COLS = 80
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // char_code [7:0], color [15:8], cell_index [26:16], zero fill [31:27]
  input  logic [tcw_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // cmd [1:0]
  input  logic [tcw_pkg::CMD_W-1:0]       s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // cursor_cell [10:0], scrolled [11], read_char [19:12], read_attr [27:20],
  // zero fill [31:28]
  output logic [tcw_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [tcw_pkg::ATTR_W-1:0]      cfg_data_i
);
  import tcw_pkg::*;

  ctrl_cmd_t             ctrl_cmd;
  dp_stat_t              dp_stat;
  logic [CELL_IDX_W-1:0] out_cursor;
  logic                  out_scrolled;
  logic [CHAR_W-1:0]     out_char;
  logic [ATTR_W-1:0]     out_attr;

  assign cfg_ready_o = 1'b1;

  tcw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (dp_stat),
    .cmd_o      (ctrl_cmd)
  );

  tcw_datapath #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (ctrl_cmd),
    .stat_o         (dp_stat),
    .in_cmd_i       (s_axis_tuser),
    .in_char_i      (s_axis_tdata[7:0]),
    .in_color_i     (s_axis_tdata[15:8]),
    .in_index_i     (s_axis_tdata[26:16]),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_data_i     (cfg_data_i),
    .out_ready_i    (m_axis_tready),
    .out_valid_o    (m_axis_tvalid),
    .out_cursor_o   (out_cursor),
    .out_scrolled_o (out_scrolled),
    .out_char_o     (out_char),
    .out_attr_o     (out_attr)
  );

  assign m_axis_tdata = {4'b0000, out_attr, out_char, out_scrolled, out_cursor};

endmodule

/* rtl/tcw_ctrl.sv */
// tcw_ctrl: sequencing state machine of the text console writer
// depends on tcw_pkg; drives tcw_datapath through ctrl_cmd_t
module tcw_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  tcw_pkg::dp_stat_t   stat_i,
  output tcw_pkg::ctrl_cmd_t  cmd_o
);
  import tcw_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_INIT: begin
        cmd_o.fill      = 1'b1;
        cmd_o.fill_zero = 1'b1;
        if (stat_i.fill_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        if (stat_i.is_clear) begin
          state_d = ST_CLEAR;
        end else if (stat_i.is_read) begin
          state_d = ST_READ;
        end else if (stat_i.need_scroll) begin
          state_d = ST_SCROLL;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_CLEAR: begin
        cmd_o.fill = 1'b1;
        if (stat_i.fill_last) begin
          state_d = ST_DONE;
        end
      end
      ST_SCROLL: begin
        cmd_o.scroll = 1'b1;
        if (stat_i.scroll_last) begin
          state_d = ST_DONE;
        end
      end
      ST_READ: begin
        cmd_o.capture = 1'b1;
        state_d       = ST_DONE;
      end
      ST_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/tcw_datapath.sv */
// tcw_datapath: screen store, cursor, sweep counter and result register
// depends on tcw_pkg; commanded by tcw_ctrl
module tcw_datapath #(
  parameter int ROWS = 25,
  parameter int COLS = 80
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  tcw_pkg::ctrl_cmd_t                  cmd_i,
  output tcw_pkg::dp_stat_t                   stat_o,
  input  logic [tcw_pkg::CMD_W-1:0]           in_cmd_i,
  input  logic [tcw_pkg::CHAR_W-1:0]          in_char_i,
  input  logic [tcw_pkg::ATTR_W-1:0]          in_color_i,
  input  logic [tcw_pkg::CELL_IDX_W-1:0]      in_index_i,
  input  logic                                cfg_valid_i,
  input  logic [tcw_pkg::ATTR_W-1:0]          cfg_data_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic [tcw_pkg::CELL_IDX_W-1:0]      out_cursor_o,
  output logic                                out_scrolled_o,
  output logic [tcw_pkg::CHAR_W-1:0]          out_char_o,
  output logic [tcw_pkg::ATTR_W-1:0]          out_attr_o
);
  import tcw_pkg::*;

  localparam int CELLS  = ROWS * COLS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int CNT_W  = ADDR_W + 1;
  localparam int COL_W  = $clog2(COLS);
  localparam int CELL_W = CHAR_W + ATTR_W;

  logic [CELL_W-1:0]     screen_q [CELLS];
  logic [CELL_W-1:0]     rdata_q;
  logic                  we;
  logic [ADDR_W-1:0]     waddr;
  logic [CELL_W-1:0]     wdata;
  logic [ADDR_W-1:0]     raddr;

  logic [CMD_W-1:0]      cmd_q;
  logic [CHAR_W-1:0]     char_q;
  logic [ATTR_W-1:0]     color_q;
  logic [CELL_IDX_W-1:0] idx_q;
  logic [ATTR_W-1:0]     clear_attr_q;

  logic [ADDR_W-1:0]     cur_q;
  logic [COL_W-1:0]      col_q;
  logic [CNT_W-1:0]      cnt_q;
  logic                  wv_q;
  logic [ADDR_W-1:0]     wa_q;
  logic                  wmove_q;
  logic                  scrolled_q;
  logic [CHAR_W-1:0]     res_char_q;
  logic [ATTR_W-1:0]     res_attr_q;
  logic                  out_valid_q;

  logic                  is_put, is_nl, is_bs, is_nul, in_range;
  logic [CNT_W-1:0]      cur_inc, cur_nl, cur_next, scroll_src;
  logic [31:0]           cur_ext;

  assign is_put   = (cmd_q == CMD_PUT);
  assign is_nl    = (char_q == CHAR_NEWLINE);
  assign is_bs    = (char_q == CHAR_BACKSPACE);
  assign is_nul   = (char_q == CHAR_NUL);
  assign in_range = (32'(idx_q) < 32'(CELLS));

  assign cur_inc    = {1'b0, cur_q} + CNT_W'(1);
  assign cur_nl     = {1'b0, cur_q} - CNT_W'(col_q) + CNT_W'(COLS);
  assign cur_next   = is_nl ? cur_nl : cur_inc;
  assign scroll_src = cnt_q + CNT_W'(COLS);
  assign cur_ext    = 32'(cur_q);

  assign stat_o.need_scroll = is_put && !is_bs && !is_nul && (cur_next == CNT_W'(CELLS));
  assign stat_o.is_clear    = (cmd_q == CMD_CLEAR);
  assign stat_o.is_read     = (cmd_q == CMD_READ);
  assign stat_o.fill_last   = (cnt_q == CNT_W'(CELLS - 1));
  assign stat_o.scroll_last = (cnt_q == CNT_W'(CELLS));
  assign stat_o.out_free    = !out_valid_q || out_ready_i;

  // single write port shared by scroll, fill and put
  always_comb begin
    we    = 1'b0;
    waddr = cur_q;
    wdata = {color_q, char_q};
    if (wv_q) begin
      we    = 1'b1;
      waddr = wa_q;
      wdata = wmove_q ? rdata_q : '0;
    end else if (cmd_i.fill) begin
      we    = 1'b1;
      waddr = cnt_q[ADDR_W-1:0];
      wdata = cmd_i.fill_zero ? '0 : {clear_attr_q, CHAR_SPACE};
    end else if (cmd_i.exec && is_put) begin
      if (is_bs) begin
        we    = (cur_q != '0);
        waddr = cur_q - ADDR_W'(1);
        wdata = {color_q, CHAR_SPACE};
      end else if (!is_nl && !is_nul) begin
        we = 1'b1;
      end
    end
  end

  assign raddr = cmd_i.scroll ? scroll_src[ADDR_W-1:0] : idx_q[ADDR_W-1:0];

  always_ff @(posedge clk_i) begin
    if (we) begin
      screen_q[waddr] <= wdata;
    end
    rdata_q <= screen_q[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_attr_q <= ATTR_W'(15);
    end else if (cfg_valid_i) begin
      clear_attr_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cmd_q   <= in_cmd_i;
      char_q  <= in_char_i;
      color_q <= in_color_i;
      idx_q   <= in_index_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q <= '0;
      col_q <= '0;
    end else if (cmd_i.exec) begin
      case (cmd_q)
        CMD_PUT: begin
          if (is_nl) begin
            col_q <= '0;
            cur_q <= stat_o.need_scroll ? ADDR_W'(CELLS - COLS) : cur_nl[ADDR_W-1:0];
          end else if (is_bs) begin
            if (cur_q != '0) begin
              cur_q <= cur_q - ADDR_W'(1);
              col_q <= (col_q == '0) ? COL_W'(COLS - 1) : col_q - COL_W'(1);
            end
          end else if (!is_nul) begin
            col_q <= (col_q == COL_W'(COLS - 1)) ? '0 : col_q + COL_W'(1);
            cur_q <= stat_o.need_scroll ? ADDR_W'(CELLS - COLS) : cur_inc[ADDR_W-1:0];
          end
        end
        CMD_CLEAR: begin
          cur_q <= '0;
          col_q <= '0;
        end
        default: begin
          cur_q <= cur_q;
        end
      endcase
    end
  end

  // sweep counter and registered write stage of the row move
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      wv_q  <= 1'b0;
    end else begin
      if (cmd_i.exec) begin
        cnt_q <= '0;
      end else if (cmd_i.fill || cmd_i.scroll) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
      wv_q <= cmd_i.scroll && (cnt_q < CNT_W'(CELLS));
    end
  end

  always_ff @(posedge clk_i) begin
    wa_q    <= cnt_q[ADDR_W-1:0];
    wmove_q <= (cnt_q < CNT_W'(CELLS - COLS));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      scrolled_q <= stat_o.need_scroll;
      res_char_q <= '0;
      res_attr_q <= '0;
    end else if (cmd_i.capture) begin
      res_char_q <= in_range ? rdata_q[CHAR_W-1:0] : '0;
      res_attr_q <= in_range ? rdata_q[CELL_W-1:CHAR_W] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_cursor_o   <= cur_ext[CELL_IDX_W-1:0];
      out_scrolled_o <= scrolled_q;
      out_char_o     <= res_char_q;
      out_attr_o     <= res_attr_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* bench/text_console_writer_test.sv */
// text_console_writer_test: self-checking bench for the text console writer
// a scoreboard class mirrors the screen store, cursor and clear attribute
// and checks each result; depends on tcw_pkg and text_console_writer
module text_console_writer_test;

  localparam int ROWS  = 25;
  localparam int COLS  = 80;
  localparam int CELLS = ROWS * COLS;

  localparam logic [tcw_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam int STALL_LIMIT     = 10000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES    = 50;

  typedef struct packed {
    logic [3:0] fill;
    logic [7:0] read_attr;
    logic [7:0] read_char;
    logic       scrolled;
    logic [10:0] cursor_cell;
  } console_result_t;

  class console_scoreboard;
    logic [15:0]     screen [CELLS];
    int unsigned     cursor;
    logic [7:0]      clear_attr;
    console_result_t pending [$];
    int              errors;

    function new();
      foreach (screen[i]) screen[i] = '0;
      cursor     = 0;
      clear_attr = 8'd15;
      errors     = 0;
    endfunction

    function logic scroll_up();
      int i;
      if (cursor < CELLS) return 1'b0;
      for (i = 0; i < CELLS - COLS; i++) screen[i] = screen[i + COLS];
      for (i = CELLS - COLS; i < CELLS; i++) screen[i] = '0;
      cursor -= COLS;
      return 1'b1;
    endfunction

    function void note_input(logic [1:0] cmd, logic [7:0] ch, logic [7:0] color,
                             logic [10:0] idx);
      console_result_t res;
      int i;
      res = '0;
      case (cmd)
        tcw_pkg::CMD_PUT: begin
          if (ch == tcw_pkg::CHAR_NEWLINE) begin
            cursor = (cursor / COLS + 1) * COLS;
            res.scrolled = scroll_up();
          end else if (ch == tcw_pkg::CHAR_BACKSPACE) begin
            if (cursor > 0) begin
              cursor--;
              screen[cursor] = {color, tcw_pkg::CHAR_SPACE};
            end
          end else if (ch != tcw_pkg::CHAR_NUL) begin
            screen[cursor] = {color, ch};
            cursor++;
            res.scrolled = scroll_up();
          end
        end
        tcw_pkg::CMD_CLEAR: begin
          for (i = 0; i < CELLS; i++) screen[i] = {clear_attr, tcw_pkg::CHAR_SPACE};
          cursor = 0;
        end
        tcw_pkg::CMD_READ: begin
          if (idx < CELLS) begin
            res.read_char = screen[idx][7:0];
            res.read_attr = screen[idx][15:8];
          end
        end
        default: ;
      endcase
      res.cursor_cell = cursor[10:0];
      pending.push_back(res);
    endfunction

    task report(string msg);
      errors++;
      $display("%0t ERROR %s", $time, msg);
    endtask

    task compare(string field, int got, int want);
      if (got != want) report($sformatf("%s: got %0d, expected %0d", field, got, want));
    endtask

    task check_result(logic [31:0] data);
      console_result_t got, want;
      got = data;
      if (pending.size() == 0) begin
        report($sformatf("result with nothing pending, tdata %h", data));
      end else begin
        want = pending.pop_front();
        compare("cursor_cell", int'(got.cursor_cell), int'(want.cursor_cell));
        compare("scrolled", int'(got.scrolled), int'(want.scrolled));
        compare("read_char", int'(got.read_char), int'(want.read_char));
        compare("read_attr", int'(got.read_attr), int'(want.read_attr));
        compare("zero fill", int'(got.fill), int'(want.fill));
      end
    endtask
  endclass

  logic                           clk_i = 1'b0;
  logic                           rst_ni;
  logic                           s_axis_tvalid;
  logic                           s_axis_tready;
  logic [tcw_pkg::IN_DATA_W-1:0]  s_axis_tdata;
  logic [tcw_pkg::CMD_W-1:0]      s_axis_tuser;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready;
  logic [tcw_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic                           cfg_valid_i;
  logic                           cfg_ready_o;
  logic [tcw_pkg::ATTR_W-1:0]     cfg_data_i;

  console_scoreboard board = new();
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_left      = 0;
  int items_sent     = 0;
  int quiet_cycles   = 0;

  always #10 clk_i = ~clk_i;

  text_console_writer #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  // receiver with random stalls and a counted hold-off
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        m_axis_tready = 1'b0;
        hold_left--;
      end else begin
        m_axis_tready = ($urandom_range(0, 99) >= recv_stall_pct);
      end
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("text_console_writer: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task send_item(logic [1:0] cmd, logic [7:0] ch, logic [7:0] color, logic [10:0] idx);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = cmd;
    s_axis_tdata  = {5'b0, idx, color, ch};
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_input(cmd, ch, color, idx);
    items_sent++;
  endtask

  task wait_drained();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
  endtask

  task write_clear_attr(logic [7:0] value);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i  = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.clear_attr = value;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task run_traffic(int n_items);
    int goal, kind, len, pick;
    logic [10:0] idx;
    goal = items_sent + n_items;
    while (items_sent < goal) begin
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        // a line of text, mostly ended by a newline
        len = $urandom_range(1, 12);
        repeat (len) send_item(tcw_pkg::CMD_PUT, 8'($urandom_range(1, 255)),
                               8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047)));
        if ($urandom_range(0, 9) < 7)
          send_item(tcw_pkg::CMD_PUT, tcw_pkg::CHAR_NEWLINE, 8'($urandom_range(0, 255)),
                    11'($urandom_range(0, 2047)));
      end else if (kind < 67) begin
        len = $urandom_range(3, 10);
        repeat (len) send_item(tcw_pkg::CMD_PUT, tcw_pkg::CHAR_NEWLINE,
                               8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047)));
      end else if (kind < 75) begin
        len = $urandom_range(1, 5);
        repeat (len) send_item(tcw_pkg::CMD_PUT, tcw_pkg::CHAR_BACKSPACE,
                               8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047)));
      end else if (kind < 87) begin
        len = $urandom_range(1, 4);
        repeat (len) begin
          pick = $urandom_range(0, 9);
          if (pick < 5) idx = 11'((board.cursor + CELLS - $urandom_range(1, 100)) % CELLS);
          else if (pick < 8) idx = 11'($urandom_range(0, CELLS - 1));
          else idx = 11'($urandom_range(0, 2047));
          send_item(tcw_pkg::CMD_READ, 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), idx);
        end
      end else if (kind < 90) begin
        send_item(tcw_pkg::CMD_CLEAR, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  11'($urandom_range(0, 2047)));
      end else if (kind < 95) begin
        pick = $urandom_range(0, 2);
        if (pick == 0)
          send_item(tcw_pkg::CMD_PUT, tcw_pkg::CHAR_NUL, 8'($urandom_range(0, 255)),
                    11'($urandom_range(0, 2047)));
        else if (pick == 1)
          send_item(CMD_UNUSED, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    11'($urandom_range(0, 2047)));
        else
          send_item(tcw_pkg::CMD_READ, 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), 11'($urandom_range(CELLS, 2047)));
      end else begin
        // long run without newline, can wrap rows and may scroll on the last cell
        len = $urandom_range(20, 85);
        repeat (len) send_item(tcw_pkg::CMD_PUT, 8'($urandom_range(11, 255)),
                               8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047)));
      end
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    send_item(tcw_pkg::CMD_READ, 8'h00, 8'h00, 11'd0);
    send_item(tcw_pkg::CMD_PUT, tcw_pkg::CHAR_BACKSPACE, 8'h55, 11'd0);
    send_item(tcw_pkg::CMD_PUT, tcw_pkg::CHAR_NUL, 8'hff, 11'h7ff);
    send_item(CMD_UNUSED, 8'hff, 8'hff, 11'h7ff);
    send_item(tcw_pkg::CMD_PUT, 8'h41, 8'h00, 11'd0);
    send_item(tcw_pkg::CMD_PUT, 8'hff, 8'hff, 11'h7ff);
    send_item(tcw_pkg::CMD_PUT, tcw_pkg::CHAR_BACKSPACE, 8'haa, 11'd0);
    send_item(tcw_pkg::CMD_READ, 8'h00, 8'h00, 11'd1);
    send_item(tcw_pkg::CMD_READ, 8'h00, 8'h00, 11'd0);
    send_item(tcw_pkg::CMD_PUT, tcw_pkg::CHAR_NEWLINE, 8'h00, 11'd0);
    send_item(tcw_pkg::CMD_READ, 8'hff, 8'hff, 11'h7ff);
    send_item(tcw_pkg::CMD_READ, 8'h00, 8'h00, 11'(CELLS));
    send_item(tcw_pkg::CMD_READ, 8'h00, 8'h00, 11'(CELLS - 1));
    send_item(tcw_pkg::CMD_CLEAR, 8'h00, 8'h00, 11'd0);
    send_item(tcw_pkg::CMD_READ, 8'h00, 8'h00, 11'(CELLS - 1));
    send_item(tcw_pkg::CMD_PUT, tcw_pkg::CHAR_BACKSPACE, 8'h33, 11'd0);
    send_item(tcw_pkg::CMD_PUT, 8'h7f, 8'h0f, 11'd0);
    send_item(tcw_pkg::CMD_PUT, tcw_pkg::CHAR_NEWLINE, 8'hf0, 11'd0);
    send_item(CMD_UNUSED, 8'h00, 8'h00, 11'd0);
    send_item(tcw_pkg::CMD_READ, 8'h00, 8'h00, 11'd0);

    wait_drained();
    write_clear_attr(8'h00);
    hold_left = HOLD_OFF_CYCLES;
    run_traffic(70);

    wait_drained();
    write_clear_attr(8'hff);
    send_idle_pct = 45;
    run_traffic(67);

    wait_drained();
    write_clear_attr(8'($urandom_range(1, 254)));
    send_idle_pct  = 0;
    recv_stall_pct = 45;
    run_traffic(67);

    wait_drained();
    write_clear_attr(8'($urandom_range(1, 254)));
    send_idle_pct  = 16;
    recv_stall_pct = 16;
    run_traffic(67);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.pending.size() != 0)
      board.report($sformatf("%0d results never arrived", board.pending.size()));
    if (board.errors == 0) begin
      $display("text_console_writer: match");
    end else begin
      $display("text_console_writer: mismatch");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/tcw_pkg.sv
rtl/tcw_ctrl.sv
rtl/tcw_datapath.sv
rtl/text_console_writer.sv
bench/text_console_writer_test.sv
